### sv/lcd_pkg.sv
`default_nettype none

package lcd_pkg;

  localparam int unsigned PERIOD_BITS = 16;
  localparam int unsigned OUT_PERIOD_BITS = 16;
  localparam int unsigned PERIOD_WIDE = (PERIOD_BITS > OUT_PERIOD_BITS) ? PERIOD_BITS
                                                                       : OUT_PERIOD_BITS;
  localparam int unsigned KW_COUNT = 7;
  localparam int unsigned NUMBER_START = 7;

  localparam logic [7:0] NEWLINE = 8'd10;
  localparam logic [7:0] DIGIT_0 = 8'h30;
  localparam logic [7:0] DIGIT_9 = 8'h39;
  localparam logic [3:0] POS_MAX = 4'd15;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_OFF     = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_START   = 3'd3,
    CMD_SCALE_F = 3'd4,
    CMD_SCALE_C = 3'd5,
    CMD_LOG     = 3'd6,
    CMD_PERIOD  = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    KW_OFF     = 3'd0,
    KW_STOP    = 3'd1,
    KW_START   = 3'd2,
    KW_SCALE_F = 3'd3,
    KW_SCALE_C = 3'd4,
    KW_LOG     = 3'd5,
    KW_PERIOD  = 3'd6
  } kw_e;

  typedef struct packed {
    cmd_e                   cmd;
    logic [PERIOD_BITS-1:0] number;
  } line_result_t;

  // keyword text, last character in the low byte
  function automatic logic [63:0] kw_text(input kw_e k);
    logic [63:0] t;
    case (k)
      KW_OFF:     t = 64'("OFF");
      KW_STOP:    t = 64'("STOP");
      KW_START:   t = 64'("START");
      KW_SCALE_F: t = 64'("SCALE=F");
      KW_SCALE_C: t = 64'("SCALE=C");
      KW_LOG:     t = 64'("LOG");
      KW_PERIOD:  t = 64'("PERIOD=");
      default:    t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input kw_e k);
    logic [3:0] l;
    case (k)
      KW_OFF:     l = 4'd3;
      KW_STOP:    l = 4'd4;
      KW_START:   l = 4'd5;
      KW_SCALE_F: l = 4'd7;
      KW_SCALE_C: l = 4'd7;
      KW_LOG:     l = 4'd3;
      KW_PERIOD:  l = 4'd7;
      default:    l = 4'd0;
    endcase
    return l;
  endfunction

  function automatic logic kw_exact(input kw_e k);
    return (k != KW_LOG) && (k != KW_PERIOD);
  endfunction

  // character at position p (p below the keyword length)
  function automatic logic [7:0] kw_char(input kw_e k, input logic [3:0] p);
    logic [63:0] t;
    logic [3:0]  sh;
    t  = kw_text(k);
    sh = kw_len(k) - 4'd1 - p;
    return t[{sh[2:0], 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

### sv/lcd_line.sv
`default_nettype none

module lcd_line
  import lcd_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         step_i,
  input  wire logic [7:0]   byte_i,
  output line_result_t      result_o
);

  localparam int unsigned AW = PERIOD_BITS + 4;

  logic [3:0]             pos_q, pos_d;
  logic [KW_COUNT-1:0]    cand_q, cand_d;
  logic [PERIOD_BITS-1:0] acc_q, acc_d;
  logic                   open_q, open_d;

  logic [KW_COUNT-1:0]    hit;
  logic [AW-1:0]          acc_ext, acc_x10;
  logic                   is_digit;
  cmd_e                   cmd;

  assign is_digit = (byte_i >= DIGIT_0) && (byte_i <= DIGIT_9);
  assign acc_ext  = AW'(acc_q);
  assign acc_x10  = (acc_ext << 3) + (acc_ext << 1) + AW'(byte_i - DIGIT_0);

  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      if (!cand_q[k]) begin
        hit[k] = 1'b0;
      end else if (kw_exact(kw_e'(k))) begin
        hit[k] = (pos_q == kw_len(kw_e'(k)));
      end else if (kw_e'(k) == KW_PERIOD) begin
        hit[k] = (pos_q >= 4'd8);
      end else begin
        hit[k] = (pos_q >= kw_len(kw_e'(k)));
      end
    end
    cmd = CMD_NONE;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (hit[k]) cmd = cmd_e'(k + 1);
    end
  end

  assign result_o.cmd    = cmd;
  assign result_o.number = acc_q;

  always_comb begin
    pos_d  = pos_q;
    cand_d = cand_q;
    acc_d  = acc_q;
    open_d = open_q;
    if (step_i) begin
      if (byte_i == NEWLINE) begin
        pos_d  = '0;
        cand_d = '1;
        acc_d  = '0;
        open_d = 1'b1;
      end else begin
        for (int k = 0; k < KW_COUNT; k++) begin
          if (pos_q < kw_len(kw_e'(k))) begin
            if (byte_i != kw_char(kw_e'(k), pos_q)) cand_d[k] = 1'b0;
          end else if (kw_exact(kw_e'(k))) begin
            cand_d[k] = 1'b0;
          end
        end
        if ((pos_q >= 4'(NUMBER_START)) && open_q) begin
          if (is_digit) begin
            acc_d = (acc_x10 > AW'({PERIOD_BITS{1'b1}})) ? '1 : acc_x10[PERIOD_BITS-1:0];
          end else begin
            open_d = 1'b0;
          end
        end
        if (pos_q < POS_MAX) pos_d = pos_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      cand_q <= '1;
      acc_q  <= '0;
      open_q <= 1'b1;
    end else begin
      pos_q  <= pos_d;
      cand_q <= cand_d;
      acc_q  <= acc_d;
      open_q <= open_d;
    end
  end

endmodule

`default_nettype wire

### sv/line_command_decoder.sv
// A newline byte is registered at the input, its result in the result register.
// Throughput: one byte per cycle; one input register and one result register
// decouple the sides, so a byte is taken while a result waits, until a second
// newline reaches the input register.
// Reset: asynchronous, active low; clears the line state, period = 1,
// Fahrenheit and reporting on, shutdown off, no result pending.
`default_nettype none

module line_command_decoder
  import lcd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output      logic        s_tready_o,
  input  wire logic [7:0]  s_tdata_i,   // [7:0] rx_byte
  output      logic        m_tvalid_o,
  input  wire logic        m_tready_i,
  output      logic [23:0] m_tdata_o    // [2:0] command, [18:3] period_seconds,
                                        // [19] fahrenheit, [20] reporting,
                                        // [21] shutdown, [23:22] zero
);

  logic                   in_vld_q;
  logic [7:0]             in_byte_q;
  logic                   step, is_nl, load;
  line_result_t           line_res;

  logic [PERIOD_BITS-1:0] period_q, period_d;
  logic                   fahr_q, fahr_d;
  logic                   rep_q, rep_d;
  logic                   shut_q, shut_d;
  logic                   out_vld_q;
  logic [23:0]            out_data_q;
  logic [PERIOD_WIDE-1:0] period_wide;
  logic [15:0]            period_out;

  assign is_nl      = (in_byte_q == NEWLINE);
  assign step       = in_vld_q && (!is_nl || !out_vld_q || m_tready_i);
  assign load       = step && is_nl;
  assign s_tready_o = !in_vld_q || step;

  lcd_line u_line (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .result_o (line_res)
  );

  always_comb begin
    period_d = period_q;
    fahr_d   = fahr_q;
    rep_d    = rep_q;
    shut_d   = shut_q;
    case (line_res.cmd)
      CMD_OFF:     shut_d   = 1'b1;
      CMD_STOP:    rep_d    = 1'b0;
      CMD_START:   rep_d    = 1'b1;
      CMD_SCALE_F: fahr_d   = 1'b1;
      CMD_SCALE_C: fahr_d   = 1'b0;
      CMD_PERIOD:  period_d = line_res.number;
      default: ;
    endcase
    period_wide = PERIOD_WIDE'(period_d);
    period_out  = (period_wide > PERIOD_WIDE'({OUT_PERIOD_BITS{1'b1}})) ? '1
                                                                         : period_wide[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      period_q  <= PERIOD_BITS'(1);
      fahr_q    <= 1'b1;
      rep_q     <= 1'b1;
      shut_q    <= 1'b0;
    end else begin
      if (s_tready_o) in_vld_q <= s_tvalid_i;
      if (load) begin
        out_vld_q <= 1'b1;
        period_q  <= period_d;
        fahr_q    <= fahr_d;
        rep_q     <= rep_d;
        shut_q    <= shut_d;
      end else if (m_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) in_byte_q <= s_tdata_i;
    if (load) out_data_q <= {2'b00, shut_d, rep_d, fahr_d, period_out, line_res.cmd};
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_data_q;

endmodule

`default_nettype wire

### sv/lcd_checker.sv
`default_nettype none

module lcd_checker
  import lcd_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_tvalid_o,
  input wire logic        m_tready_i,
  input wire logic [23:0] m_tdata_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("stalled result changed");

  a_sticky_shutdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tready_i && m_tdata_o[21] |=> !m_tvalid_o || m_tdata_o[21])
    else $error("shutdown flag cleared");

  a_off_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tdata_o[2:0] == CMD_OFF) |-> m_tdata_o[21])
    else $error("off without shutdown");

  a_cmd_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> !((m_tdata_o[2:0] == CMD_SCALE_F) && !m_tdata_o[19]) &&
                   !((m_tdata_o[2:0] == CMD_SCALE_C) && m_tdata_o[19]) &&
                   !((m_tdata_o[2:0] == CMD_STOP) && m_tdata_o[20]) &&
                   !((m_tdata_o[2:0] == CMD_START) && !m_tdata_o[20]))
    else $error("command disagrees with settings");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (m_tdata_o[23:22] == 2'b00))
    else $error("tdata padding not zero");

endmodule

bind line_command_decoder lcd_checker u_lcd_checker (.*);

`default_nettype wire
